// File: sv/spts_pkg.sv
// Package for the slotted page tuple store: page geometry, op and status codes,
// sequencer states and channel payload types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spts_pkg;

  localparam int PAGE_BYTES       = 4096;
  localparam int HDR_BYTES        = 16;
  localparam int SLOT_ENTRY_BYTES = 4;
  localparam int PREFIX_BYTES     = 2;
  localparam int AW               = $clog2(PAGE_BYTES);
  localparam int XW               = 18;
  localparam int MAX_SLOTS        = PAGE_BYTES / SLOT_ENTRY_BYTES;
  localparam logic [15:0] TOMBSTONE = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_INIT     = 3'd0,
    OP_INS_BEG  = 3'd1,
    OP_INS_BYTE = 3'd2,
    OP_READ     = 3'd3,
    OP_DELETE   = 3'd4,
    OP_RAW_WR   = 3'd5,
    OP_RAW_RD   = 3'd6,
    OP_NOP      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_SEQ_ERR  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_PAGE_NUMBER  = 1'b0,
    CFG_LOG_SEQUENCE = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_ENT_RD, S_ENT_CHK, S_RD_ISS, S_RD_CAP,
    S_INS_WR, S_DEL_WR, S_HDR, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  slot;
    logic [11:0] byte_index;
    logic [11:0] page_address;
    logic [7:0]  data_byte;
    logic [11:0] tuple_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot_granted;
    logic [7:0]  byte_out;
    logic [11:0] length_out;
    logic [11:0] free_bytes;
    logic [9:0]  slots_used;
  } out_item_t;

endpackage
`default_nettype wire

// File: sv/spts_in_if.sv
// Input channel of the slotted page tuple store: valid, ready and one request item.
// Depends on spts_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface spts_in_if;
  import spts_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/spts_out_if.sv
// Result channel of the slotted page tuple store: valid, ready and one result item.
// Depends on spts_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface spts_out_if;
  import spts_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/spts_ram.sv
// Generic single-port RAM, one read or write per cycle, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module spts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: sv/slotted_page_tuple_store.sv
// Slotted page tuple store top level: sequencer, header shadow and page RAM.
// Depends on spts_pkg, spts_in_if, spts_out_if and spts_ram.
//
// One request is handled at a time by a sequencer around a single-port byte RAM;
// every page byte access is a separate RAM access. After reset a clearing pass
// zeroes the page before the first request is taken. Raw reads of the log sequence
// bytes skip the RAM. Read tuple and delete read the four slot entry bytes; a read
// past the tuple end or a tombstoned slot then ends without further access, and a
// slot past the slot count skips the directory. Insert begin scans at most 1024
// slots of the directory, reading four entry bytes per slot. A result waits in an
// output register, and the next request is taken while it does.
`timescale 1ns / 1ps
`default_nettype none
module slotted_page_tuple_store (
  input  wire logic         clk,
  input  wire logic         rst_n,
  spts_in_if.sink           in_ch,
  spts_out_if.source        out_ch,
  input  wire logic         cfg_we,
  input  wire spts_pkg::cfg_idx_t cfg_index,
  input  wire logic [63:0]  cfg_data
);
  import spts_pkg::*;

  state_t      state_r, state_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  in_item_t    req_r, req_nxt;
  logic [15:0] n_r, n_nxt, fr_r, fr_nxt, off_r, off_nxt, len_r, len_nxt;
  logic [15:0] ns_r, ns_nxt, nf_r, nf_nxt;
  logic [9:0]  es_r, es_nxt;
  logic [XW-1:0] start_r, start_nxt, cur_r, cur_nxt, taddr_r, taddr_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic [1:0]  sts_r, sts_nxt;
  logic [9:0]  gr_r, gr_nxt;
  logic [7:0]  bo_r, bo_nxt;
  logic [11:0] lo_r, lo_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   out_r, out_nxt;
  logic [31:0] pn_r;
  logic [63:0] lsn_r;
  logic [7:0]  sh_r [4];
  logic        rk_oor_r, rk_sh_r;
  logic [1:0]  rk_idx_r;

  logic          acc_we, acc_re;
  logic [XW-1:0] acc_addr;
  logic [7:0]    acc_wd, ram_q, rdata;
  logic          in_range, in_shadow, ram_we;
  logic [AW-1:0] ent_base;
  logic [12:0]   need;
  logic [XW-1:0] cand;
  logic [15:0]   hdr_slots, hdr_free;
  logic          accept;

  assign hdr_slots = {sh_r[1], sh_r[0]};
  assign hdr_free  = {sh_r[3], sh_r[2]};
  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = out_r;

  assign ent_base = AW'(PAGE_BYTES - SLOT_ENTRY_BYTES) - {es_r, 2'b00};
  assign need     = {1'b0, req_r.tuple_bytes} + 13'(PREFIX_BYTES + SLOT_ENTRY_BYTES);
  assign cand     = XW'(off_r) + XW'(PREFIX_BYTES) + XW'(len_r);

  assign in_range  = acc_addr < XW'(PAGE_BYTES);
  assign in_shadow = (acc_addr >= XW'(4)) && (acc_addr < XW'(8));
  assign ram_we    = acc_we && in_range && !in_shadow;
  assign rdata     = rk_oor_r ? 8'd0 : (rk_sh_r ? sh_r[rk_idx_r] : ram_q);

  spts_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page (
    .clk   (clk),
    .we    (ram_we),
    .addr  (acc_addr[AW-1:0]),
    .wdata (acc_wd),
    .rdata (ram_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:     if (clr_r == AW'(PAGE_BYTES - 1)) state_nxt = S_IDLE;
      S_IDLE:    if (accept) state_nxt = S_DISP;
      S_DISP: begin
        unique case (op_t'(req_r.op))
          OP_INIT:    state_nxt = S_HDR;
          OP_INS_BEG: begin
            if ({3'd0, need} > fr_r) state_nxt = S_DONE;
            else if (n_r == 16'd0) state_nxt = S_INS_WR;
            else state_nxt = S_ENT_RD;
          end
          OP_READ, OP_DELETE:
            state_nxt = ({6'd0, req_r.slot} >= n_r) ? S_DONE : S_ENT_RD;
          OP_RAW_RD:
            state_nxt = (req_r.page_address >= 12'd8 && req_r.page_address < 12'd16)
                        ? S_DONE : S_RD_ISS;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_ENT_RD:  if (k_r == 4'd4) state_nxt = S_ENT_CHK;
      S_ENT_CHK: begin
        unique case (op_t'(req_r.op))
          OP_INS_BEG:
            state_nxt = ((17'(es_r) + 17'd1 < 17'(n_r)) && (es_r != 10'(MAX_SLOTS - 1)))
                        ? S_ENT_RD : S_INS_WR;
          OP_READ:
            state_nxt = (off_r == TOMBSTONE) ? S_DONE
                        : ({4'd0, req_r.byte_index} < len_r) ? S_RD_ISS : S_DONE;
          default:
            state_nxt = (off_r == TOMBSTONE) ? S_DONE : S_DEL_WR;
        endcase
      end
      S_RD_ISS:  state_nxt = S_RD_CAP;
      S_RD_CAP:  state_nxt = S_DONE;
      S_INS_WR:  if (k_r == 4'd5) state_nxt = S_HDR;
      S_DEL_WR:  if (k_r == 4'd1) state_nxt = S_DONE;
      S_HDR:     if (k_r == 4'd15) state_nxt = S_DONE;
      S_DONE:    if (!ov_r || out_ch.ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    k_nxt = (state_nxt != state_r) ? 4'd0 : k_r + 4'd1;
    clr_nxt = clr_r + AW'(1);
    req_nxt = req_r;  n_nxt = n_r;  fr_nxt = fr_r;  off_nxt = off_r;  len_nxt = len_r;
    ns_nxt = ns_r;  nf_nxt = nf_r;  es_nxt = es_r;  start_nxt = start_r;
    cur_nxt = cur_r;  rem_nxt = rem_r;  taddr_nxt = taddr_r;
    sts_nxt = sts_r;  gr_nxt = gr_r;  bo_nxt = bo_r;  lo_nxt = lo_r;
    ov_nxt = ov_r && !out_ch.ready;
    out_nxt = out_r;
    acc_we = 1'b0;  acc_re = 1'b0;  acc_addr = '0;  acc_wd = 8'd0;

    unique case (state_r)
      S_CLR: begin
        acc_we = 1'b1;
        acc_addr = XW'(clr_r);
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_ch.data;
          n_nxt = hdr_slots;
          fr_nxt = hdr_free;
          sts_nxt = ST_OK;  gr_nxt = '0;  bo_nxt = '0;  lo_nxt = '0;
        end
      end
      S_DISP: begin
        es_nxt = req_r.slot;
        start_nxt = XW'(HDR_BYTES);
        unique case (op_t'(req_r.op))
          OP_INIT: begin
            ns_nxt = 16'd0;
            nf_nxt = 16'(PAGE_BYTES - HDR_BYTES);
            rem_nxt = '0;
          end
          OP_INS_BEG: begin
            es_nxt = 10'd0;
            if ({3'd0, need} > fr_r) begin
              sts_nxt = ST_NO_SPACE;
              rem_nxt = '0;
            end
          end
          OP_INS_BYTE: begin
            if (rem_r == '0) begin
              sts_nxt = ST_SEQ_ERR;
            end else begin
              acc_we = 1'b1;
              acc_addr = cur_r;
              acc_wd = req_r.data_byte;
              cur_nxt = cur_r + XW'(1);
              rem_nxt = rem_r - 13'd1;
            end
          end
          OP_READ, OP_DELETE: begin
            if ({6'd0, req_r.slot} >= n_r) sts_nxt = ST_EMPTY;
          end
          OP_RAW_WR: begin
            acc_we = 1'b1;
            acc_addr = XW'(req_r.page_address);
            acc_wd = req_r.data_byte;
          end
          OP_RAW_RD: begin
            taddr_nxt = XW'(req_r.page_address);
            bo_nxt = lsn_r[{req_r.page_address[2:0], 3'b000} +: 8];
          end
          default: ;
        endcase
      end
      S_ENT_RD: begin
        if (k_r < 4'd4) begin
          acc_re = 1'b1;
          acc_addr = XW'({ent_base[AW-1:2], k_r[1:0]});
        end
        unique case (k_r)
          4'd1:    off_nxt[7:0] = rdata;
          4'd2:    off_nxt[15:8] = rdata;
          4'd3:    len_nxt[7:0] = rdata;
          4'd4:    len_nxt[15:8] = rdata;
          default: ;
        endcase
      end
      S_ENT_CHK: begin
        unique case (op_t'(req_r.op))
          OP_INS_BEG: begin
            if (off_r != TOMBSTONE && cand > start_r) start_nxt = cand;
            es_nxt = (state_nxt == S_ENT_RD) ? es_r + 10'd1 : n_r[9:0];
          end
          OP_READ: begin
            if (off_r == TOMBSTONE) begin
              sts_nxt = ST_EMPTY;
            end else begin
              lo_nxt = len_r[11:0];
              taddr_nxt = XW'(off_r) + XW'(PREFIX_BYTES) + XW'(req_r.byte_index);
            end
          end
          default: if (off_r == TOMBSTONE) sts_nxt = ST_EMPTY;
        endcase
      end
      S_RD_ISS: begin
        acc_re = 1'b1;
        acc_addr = taddr_r;
      end
      S_RD_CAP: bo_nxt = rdata;
      S_INS_WR: begin
        unique case (k_r)
          4'd0: begin acc_we = 1'b1; acc_addr = start_r; acc_wd = req_r.tuple_bytes[7:0]; end
          4'd1: begin
            acc_we = 1'b1;
            acc_addr = start_r + XW'(1);
            acc_wd = {4'd0, req_r.tuple_bytes[11:8]};
          end
          default: begin
            acc_we = (n_r < 16'(MAX_SLOTS));
            acc_addr = XW'({ent_base[AW-1:2], 2'(k_r - 4'd2)});
            unique case (k_r)
              4'd2:    acc_wd = start_r[7:0];
              4'd3:    acc_wd = start_r[15:8];
              4'd4:    acc_wd = req_r.tuple_bytes[7:0];
              default: acc_wd = {4'd0, req_r.tuple_bytes[11:8]};
            endcase
          end
        endcase
        if (k_r == 4'd5) begin
          ns_nxt = n_r + 16'd1;
          nf_nxt = fr_r - {3'd0, need};
          cur_nxt = start_r + XW'(PREFIX_BYTES);
          rem_nxt = {1'b0, req_r.tuple_bytes};
          gr_nxt = n_r[9:0];
        end
      end
      S_DEL_WR: begin
        acc_we = 1'b1;
        acc_addr = XW'({ent_base[AW-1:2], k_r[1:0]});
        acc_wd = TOMBSTONE[7:0];
      end
      S_HDR: begin
        acc_we = 1'b1;
        acc_addr = XW'(k_r);
        priority if (k_r < 4'd4) acc_wd = pn_r[{k_r[1:0], 3'b000} +: 8];
        else if (k_r == 4'd4) acc_wd = ns_r[7:0];
        else if (k_r == 4'd5) acc_wd = ns_r[15:8];
        else if (k_r == 4'd6) acc_wd = nf_r[7:0];
        else if (k_r == 4'd7) acc_wd = nf_r[15:8];
        else acc_wd = lsn_r[{k_r[2:0], 3'b000} +: 8];
      end
      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          out_nxt.status = sts_r;
          out_nxt.slot_granted = gr_r;
          out_nxt.byte_out = bo_r;
          out_nxt.length_out = lo_r;
          out_nxt.free_bytes = hdr_free[11:0];
          out_nxt.slots_used = hdr_slots[9:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      k_r     <= '0;
      clr_r   <= '0;
      rem_r   <= '0;
      cur_r   <= '0;
      ov_r    <= 1'b0;
      pn_r    <= '0;
      lsn_r   <= '0;
      for (int i = 0; i < 4; i++) sh_r[i] <= 8'd0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      clr_r   <= clr_nxt;
      rem_r   <= rem_nxt;
      cur_r   <= cur_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PAGE_NUMBER:  pn_r  <= cfg_data[31:0];
          CFG_LOG_SEQUENCE: lsn_r <= cfg_data;
          default: ;
        endcase
      end
      if (acc_we && in_range && in_shadow) sh_r[acc_addr[1:0]] <= acc_wd;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;  n_r <= n_nxt;  fr_r <= fr_nxt;  off_r <= off_nxt;  len_r <= len_nxt;
    ns_r <= ns_nxt;  nf_r <= nf_nxt;  es_r <= es_nxt;  start_r <= start_nxt;
    taddr_r <= taddr_nxt;  sts_r <= sts_nxt;  gr_r <= gr_nxt;  bo_r <= bo_nxt;
    lo_r <= lo_nxt;  out_r <= out_nxt;
    if (acc_re) begin
      rk_oor_r <= !in_range;
      rk_sh_r  <= in_shadow;
      rk_idx_r <= acc_addr[1:0];
    end
  end

  a_ram_in_page: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> acc_addr < XW'(PAGE_BYTES))
    else $error("page RAM write outside the page");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 13'd4095)
    else $error("insert count out of range");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside completion");

  a_no_access_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !acc_we && !acc_re)
    else $error("memory access while idle");

endmodule
`default_nettype wire
